[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion macros
// Implication forms on the rising clock edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// ante holds in a cycle -> cons holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/ss_pkg.sv]
// ----------------------------------------------------------------------------
// ss_pkg: shared types and constants of the substring search block
// Sizes of the pattern window and position counter, register codes and the
// structs passed between the window chain and the string tracker.
// ----------------------------------------------------------------------------
package ss_pkg;

	localparam int MAX_PATTERN    = 16;
	localparam int WINDOW_DEPTH   = MAX_PATTERN - 1;
	localparam int MAX_STRING_LEN = 65536;
	localparam int POS_W          = $clog2(MAX_STRING_LEN) + 1;
	localparam int PLEN_W         = $clog2(MAX_PATTERN + 1);
	localparam int PIDX_W         = $clog2(MAX_PATTERN);
	localparam int IDX_W          = 16;
	localparam int CHAR_W         = 8;
	localparam int CFG_W          = 64;
	localparam int CFG_IDX_W      = 2;
	localparam int OUT_DATA_W     = 40;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LOW  = 2'd0,
		REG_PAT_HIGH = 2'd1,
		REG_PAT_LEN  = 2'd2
	} cfg_reg_t;

	typedef logic [CHAR_W-1:0] char_t;

	// one accepted input item as seen by the tracker
	typedef struct packed {
		logic valid;
		logic has_char;
		logic last;
		logic win_hit;
	} step_t;

	typedef struct packed {
		logic             too_long;
		logic             ends_match;
		logic             starts_match;
		logic [IDX_W-1:0] last_index;
		logic [IDX_W-1:0] first_index;
		logic             found;
	} result_t;

endpackage

[design/ss_cell.sv]
// ----------------------------------------------------------------------------
// ss_cell: one window cell
// Holds one recent character, hands it to the next cell on every shift and
// compares it against the pattern byte aligned to its place.
// ----------------------------------------------------------------------------
module ss_cell (
	input  logic          clk,
	input  logic          shift,
	input  ss_pkg::char_t char_in,
	input  ss_pkg::char_t pat_byte,
	input  logic          active,
	output ss_pkg::char_t char_q,
	output logic          eq
);

	always_ff @(posedge clk) begin
		if (shift) begin
			char_q <= char_in;
		end
	end

	// cells beyond the pattern length always agree
	assign eq = !active || (char_q == pat_byte);

endmodule

[design/ss_tracker.sv]
// ----------------------------------------------------------------------------
// ss_tracker: per-string match bookkeeping
// Counts characters, records first and last match start, start and end
// matches and overflow, and forms the result on the closing item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ss_tracker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ss_pkg::step_t              step,
	input  logic [ss_pkg::PLEN_W-1:0]  plen,
	output logic                       res_valid,
	output ss_pkg::result_t            res
);

	localparam logic [ss_pkg::POS_W-1:0] POS_MAX = ss_pkg::POS_W'(ss_pkg::MAX_STRING_LEN);

	logic [ss_pkg::POS_W-1:0] pos_q, pos_n, pos_inc, plen_ext, diff;
	logic [ss_pkg::IDX_W-1:0] first_q, first_n, last_q, last_n;
	logic any_q, any_n, start_q, start_n, latest_q, latest_n, ovf_q, ovf_n;
	logic hit, in_range, empty;

	always_comb begin
		pos_inc  = pos_q + ss_pkg::POS_W'(1);
		plen_ext = ss_pkg::POS_W'(plen);
		diff     = pos_inc - plen_ext;
		hit      = step.win_hit && (pos_inc >= plen_ext);
		in_range = pos_q < POS_MAX;

		pos_n    = pos_q;
		first_n  = first_q;
		last_n   = last_q;
		any_n    = any_q;
		start_n  = start_q;
		latest_n = latest_q;
		ovf_n    = ovf_q;
		if (step.has_char) begin
			latest_n = hit;
			if (in_range) begin
				if (hit) begin
					if (!any_q) begin
						first_n = diff[ss_pkg::IDX_W-1:0];
					end
					last_n = diff[ss_pkg::IDX_W-1:0];
					any_n  = 1'b1;
					if (pos_inc == plen_ext) begin
						start_n = 1'b1;
					end
				end
				pos_n = pos_inc;
			end else begin
				ovf_n = 1'b1;
			end
		end

		empty     = (pos_n == '0) && !ovf_n;
		res_valid = step.valid && step.last;
		if (plen == '0) begin
			res.found        = empty;
			res.first_index  = '0;
			res.last_index   = '0;
			res.starts_match = empty;
			res.ends_match   = 1'b1;
		end else begin
			res.found        = any_n;
			res.first_index  = any_n ? first_n : '0;
			res.last_index   = any_n ? last_n : '0;
			res.starts_match = start_n;
			res.ends_match   = latest_n && (pos_n != '0);
		end
		res.too_long = ovf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			first_q  <= '0;
			last_q   <= '0;
			any_q    <= 1'b0;
			start_q  <= 1'b0;
			latest_q <= 1'b0;
			ovf_q    <= 1'b0;
		end else if (step.valid && step.last) begin
			// close the string: clear for the next one
			pos_q    <= '0;
			first_q  <= '0;
			last_q   <= '0;
			any_q    <= 1'b0;
			start_q  <= 1'b0;
			latest_q <= 1'b0;
			ovf_q    <= 1'b0;
		end else if (step.valid) begin
			pos_q    <= pos_n;
			first_q  <= first_n;
			last_q   <= last_n;
			any_q    <= any_n;
			start_q  <= start_n;
			latest_q <= latest_n;
			ovf_q    <= ovf_n;
		end
	end

	`ASSERT_IMPL(a_pos_bound, clk, arst_n, 1'b1, pos_q <= POS_MAX, "position beyond saturation")
	`ASSERT_IMPL(a_ovf_sat, clk, arst_n, ovf_q, pos_q == POS_MAX, "overflow without saturated position")
	`ASSERT_NEXT(a_close_clear, clk, arst_n, step.valid && step.last, (pos_q == '0) && !any_q && !ovf_q, "string state not cleared")

endmodule

[design/substring_search.sv]
// ----------------------------------------------------------------------------
// substring_search: streamed substring search against a stored pattern
// Characters of a string arrive one per transaction and are matched against
// a pattern of up to 16 bytes through a chain of window cells.
// ----------------------------------------------------------------------------
// Usage:
//   Write pattern_bytes_low (index 0), pattern_bytes_high (index 1) and
//   pattern_length (index 2) through cfg_we/cfg_index/cfg_data while idle.
//   Send a string on s_axis: tdata = character, tuser = character present,
//   tlast = final transaction of the string. An item with tuser low and
//   tlast high closes an empty string; tuser low and tlast low is ignored.
//   One result per string leaves on m_axis, registered into the output or
//   skid entry on the closing transaction; other transactions produce nothing.
//   Throughput: one transaction per cycle while s_axis_tready is high; the
//   window compare over all cells and the tracker update settle in the accept cycle.
//   An output register plus a skid entry hold up to two results; s_axis
//   tready drops only while the skid entry is occupied, i.e. after a result
//   was produced while m_axis was stalled with a result already waiting.
//   Reset clears the pattern registers, the string state and both result
//   entries; no clearing pass is needed afterward.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module substring_search (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ss_pkg::CFG_W-1:0]          cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [ss_pkg::CHAR_W-1:0]         s_axis_tdata,  // char_value
	input  logic                              s_axis_tuser,  // has_char
	input  logic                              s_axis_tlast,  // end_of_string
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// found, first_index, last_index, starts_match, ends_match, too_long, zero fill
	output logic [ss_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

	localparam int RES_W = $bits(ss_pkg::result_t);

	logic [ss_pkg::CFG_W-1:0]   pat_low_q, pat_high_q;
	logic [ss_pkg::PLEN_W-1:0]  len_q, plen;
	ss_pkg::char_t              pat [ss_pkg::MAX_PATTERN];
	ss_pkg::char_t              aligned [ss_pkg::MAX_PATTERN];
	logic [ss_pkg::MAX_PATTERN-1:0] active, eq;
	ss_pkg::char_t              chain [ss_pkg::WINDOW_DEPTH+1];
	logic                       accept, shift, win_hit;
	ss_pkg::step_t              step;
	logic                       res_valid;
	ss_pkg::result_t            res, out_q, skid_q;
	logic                       out_valid_q, skid_valid_q, take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			len_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ss_pkg::REG_PAT_LOW:  pat_low_q  <= cfg_data;
				ss_pkg::REG_PAT_HIGH: pat_high_q <= cfg_data;
				ss_pkg::REG_PAT_LEN:  len_q      <= cfg_data[ss_pkg::PLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// align the pattern so that cell k sees the byte k places before its end
	always_comb begin
		logic [ss_pkg::PLEN_W-1:0] sel;
		plen = (len_q > ss_pkg::PLEN_W'(ss_pkg::MAX_PATTERN))
			? ss_pkg::PLEN_W'(ss_pkg::MAX_PATTERN) : len_q;
		for (int k = 0; k < ss_pkg::MAX_PATTERN; k++) begin
			if (k < 8) begin
				pat[k] = pat_low_q[8*k +: 8];
			end else begin
				pat[k] = pat_high_q[8*(k-8) +: 8];
			end
		end
		for (int k = 0; k < ss_pkg::MAX_PATTERN; k++) begin
			sel        = plen - ss_pkg::PLEN_W'(k) - ss_pkg::PLEN_W'(1);
			aligned[k] = pat[sel[ss_pkg::PIDX_W-1:0]];
			active[k]  = ss_pkg::PLEN_W'(k) < plen;
		end
	end

	assign s_axis_tready = !skid_valid_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign shift         = accept && s_axis_tuser;

	// newest character compares at the head of the chain
	assign chain[0] = s_axis_tdata;
	assign eq[0]    = !active[0] || (s_axis_tdata == aligned[0]);

	for (genvar g = 1; g <= ss_pkg::WINDOW_DEPTH; g++) begin : g_cell
		ss_cell u_cell (
			.clk      (clk),
			.shift    (shift),
			.char_in  (chain[g-1]),
			.pat_byte (aligned[g]),
			.active   (active[g]),
			.char_q   (chain[g]),
			.eq       (eq[g])
		);
	end

	assign win_hit = (plen != '0) && (&eq);

	assign step.valid    = accept;
	assign step.has_char = s_axis_tuser;
	assign step.last     = s_axis_tlast;
	assign step.win_hit  = win_hit;

	ss_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.plen      (plen),
		.res_valid (res_valid),
		.res       (res)
	);

	// output register with one skid entry
	assign take = out_valid_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (res_valid) begin
			if (out_valid_q && !take) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(ss_pkg::OUT_DATA_W - RES_W)'(0), out_q};

	`ASSERT_IMPL(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q, "skid entry without output entry")

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench of the streamed substring search block
// Drives strings on the input stream in bursts with random gaps, writes the
// pattern registers between phases and checks every result against a local
// predictor of the window match and the per-string tracker. Covers empty
// strings and patterns, pattern length saturation, changes of the pattern
// between the characters of one string and strings past the position range.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ss_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 450;
	localparam int SETTLE_CYCLES = 4;

	typedef struct {
		ss_pkg::char_t value;
		logic          has_char;
		logic          last;
	} str_item_t;

	typedef enum {LEAVE_OPEN, CLOSE_ON_CHAR, CLOSE_BY_MARKER} close_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ss_pkg::CFG_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [ss_pkg::CHAR_W-1:0] s_axis_tdata = '0;   // char_value
	logic s_axis_tuser = 1'b0;                      // has_char
	logic s_axis_tlast = 1'b0;                      // end_of_string
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// found, first_index, last_index, starts_match, ends_match, too_long, zero fill
	logic [ss_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	substring_search dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	str_item_t pending_items[$];
	ss_pkg::result_t expected_results[$];
	int fail_count = 0;
	int stream_items = 0;
	bit item_taken = 1'b0;

	// pattern registers as the block holds them
	logic [ss_pkg::CFG_W-1:0] pat_low_reg = '0;
	logic [ss_pkg::CFG_W-1:0] pat_high_reg = '0;
	logic [ss_pkg::PLEN_W-1:0] pat_len_reg = '0;

	// per-string tracking
	ss_pkg::char_t recent[ss_pkg::WINDOW_DEPTH];
	int pos_count = 0;
	logic any_hit = 1'b0;
	logic [ss_pkg::IDX_W-1:0] first_start = '0;
	logic [ss_pkg::IDX_W-1:0] last_start = '0;
	logic hit_at_start = 1'b0;
	logic hit_at_latest = 1'b0;
	logic overflowed = 1'b0;

	initial foreach (recent[i]) recent[i] = '0;

	function automatic ss_pkg::char_t pattern_byte(input int k);
		if (k < 8)
			return pat_low_reg[8*k +: 8];
		return pat_high_reg[8*(k-8) +: 8];
	endfunction

	task automatic track_item(input ss_pkg::char_t c, input logic has, input logic last);
		int plen;
		logic hit;
		ss_pkg::char_t have;
		ss_pkg::result_t r;
		plen = (pat_len_reg > ss_pkg::MAX_PATTERN) ? ss_pkg::MAX_PATTERN : int'(pat_len_reg);
		if (has) begin
			hit = (plen != 0) && (pos_count + 1 >= plen);
			for (int k = 0; k < plen; k++) begin
				have = (k == 0) ? c : recent[k-1];
				if (have != pattern_byte(plen - 1 - k))
					hit = 1'b0;
			end
			hit_at_latest = hit;
			if (pos_count < ss_pkg::MAX_STRING_LEN) begin
				if (hit) begin
					if (!any_hit)
						first_start = ss_pkg::IDX_W'(pos_count + 1 - plen);
					last_start = ss_pkg::IDX_W'(pos_count + 1 - plen);
					any_hit = 1'b1;
					if (pos_count + 1 == plen)
						hit_at_start = 1'b1;
				end
				pos_count++;
			end else begin
				overflowed = 1'b1;
			end
			for (int k = ss_pkg::WINDOW_DEPTH - 1; k > 0; k--)
				recent[k] = recent[k-1];
			recent[0] = c;
		end
		if (last) begin
			if (plen == 0) begin
				r.found = (pos_count == 0) && !overflowed;
				r.first_index = '0;
				r.last_index = '0;
				r.starts_match = r.found;
				r.ends_match = 1'b1;
			end else begin
				r.found = any_hit;
				r.first_index = any_hit ? first_start : '0;
				r.last_index = any_hit ? last_start : '0;
				r.starts_match = hit_at_start;
				r.ends_match = hit_at_latest && (pos_count != 0);
			end
			r.too_long = overflowed;
			expected_results.push_back(r);
			foreach (recent[i]) recent[i] = '0;
			pos_count = 0;
			any_hit = 1'b0;
			first_start = '0;
			last_start = '0;
			hit_at_start = 1'b0;
			hit_at_latest = 1'b0;
			overflowed = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// predict accepted input, check delivered results, track register writes
	always @(posedge clk) begin : monitor
		ss_pkg::result_t got;
		ss_pkg::result_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				track_item(s_axis_tdata, s_axis_tuser, s_axis_tlast);
				item_taken = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = ss_pkg::result_t'(m_axis_tdata[$bits(ss_pkg::result_t)-1:0]);
				if (expected_results.size() == 0) begin
					$error("unexpected result %h", m_axis_tdata);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("found", want.found, got.found);
					check_field("first_index", want.first_index, got.first_index);
					check_field("last_index", want.last_index, got.last_index);
					check_field("starts_match", want.starts_match, got.starts_match);
					check_field("ends_match", want.ends_match, got.ends_match);
					check_field("too_long", want.too_long, got.too_long);
					check_field("zero fill", 0,
						m_axis_tdata[ss_pkg::OUT_DATA_W-1:$bits(ss_pkg::result_t)]);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					ss_pkg::REG_PAT_LOW: pat_low_reg = cfg_data;
					ss_pkg::REG_PAT_HIGH: pat_high_reg = cfg_data;
					ss_pkg::REG_PAT_LEN: pat_len_reg = cfg_data[ss_pkg::PLEN_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// sender: bursts of transactions separated by random gaps
	int burst_left = 1;
	int gap_left = 0;

	always @(negedge clk) begin : driver
		str_item_t item;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || item_taken) begin
			item_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				item = pending_items.pop_front();
				s_axis_tdata <= item.value;
				s_axis_tuser <= item.has_char;
				s_axis_tlast <= item.last;
				s_axis_tvalid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96)
						: $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: rotate through an 8-bit ready pattern, pick a new one each lap
	logic [7:0] ready_pattern = 8'hFF;
	int ready_phase = 0;

	always @(negedge clk) begin : receiver
		m_axis_tready <= ready_pattern[ready_phase];
		if (ready_phase == 7) begin
			ready_phase = 0;
			case ($urandom_range(0, 3))
				0: ready_pattern = 8'hFF;
				1: ready_pattern = 8'($urandom) & 8'($urandom);
				default: ready_pattern = 8'($urandom);
			endcase
		end else begin
			ready_phase++;
		end
	end

	task automatic push_item(input ss_pkg::char_t value, input logic has, input logic last);
		pending_items.push_back('{value, has, last});
		if (has || last)
			stream_items++;
	endtask

	task automatic push_string(ref ss_pkg::char_t s[$], input close_mode_t mode,
		input bit noisy);
		foreach (s[i]) begin
			if (noisy && $urandom_range(0, 15) == 0)
				push_item(ss_pkg::char_t'($urandom), 1'b0, 1'b0);
			push_item(s[i], 1'b1, mode == CLOSE_ON_CHAR && i == s.size() - 1);
		end
		if (mode == CLOSE_BY_MARKER || (mode == CLOSE_ON_CHAR && s.size() == 0))
			push_item(ss_pkg::char_t'($urandom), 1'b0, 1'b1);
	endtask

	function automatic void plant(ref ss_pkg::char_t s[$],
		input ss_pkg::char_t pat[ss_pkg::MAX_PATTERN], input int at, input int plen);
		for (int k = 0; k < plen; k++)
			s[at + k] = pat[k];
	endfunction

	task automatic write_reg(input logic [ss_pkg::CFG_IDX_W-1:0] index,
		input logic [ss_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold until the sender is empty and every result is in, then settle
	task automatic wait_idle();
		int waited;
		waited = 0;
		while (pending_items.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (expected_results.size() != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			fail_count++;
			expected_results.delete();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic random_phase();
		ss_pkg::char_t alpha[4];
		ss_pkg::char_t pat[ss_pkg::MAX_PATTERN];
		ss_pkg::char_t s[$];
		logic [ss_pkg::CFG_W-1:0] lo;
		logic [ss_pkg::CFG_W-1:0] hi;
		logic [ss_pkg::CFG_W-1:0] len_word;
		int plen_raw;
		int plen;
		int len;
		int at;
		int phase_start;
		case ($urandom_range(0, 9))
			0: plen_raw = 0;
			1: plen_raw = ss_pkg::MAX_PATTERN;
			2: plen_raw = $urandom_range(ss_pkg::MAX_PATTERN + 1, 31);
			default: plen_raw = $urandom_range(1, 6);
		endcase
		plen = (plen_raw > ss_pkg::MAX_PATTERN) ? ss_pkg::MAX_PATTERN : plen_raw;
		if ($urandom_range(0, 4) == 0) begin
			// extreme bytes only
			alpha = '{8'h00, 8'hFF, 8'h00, 8'hFF};
			foreach (pat[i]) pat[i] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
		end else begin
			foreach (alpha[i]) alpha[i] = ss_pkg::char_t'($urandom);
			foreach (pat[i]) pat[i] = alpha[$urandom_range(0, 3)];
		end
		for (int i = 0; i < 8; i++) begin
			lo[8*i +: 8] = pat[i];
			hi[8*i +: 8] = pat[8 + i];
		end
		len_word = ($urandom_range(0, 1) != 0) ? {$urandom, $urandom} : '0;
		len_word[ss_pkg::PLEN_W-1:0] = ss_pkg::PLEN_W'(plen_raw);
		write_reg(ss_pkg::REG_PAT_LOW, lo);
		write_reg(ss_pkg::REG_PAT_HIGH, hi);
		write_reg(ss_pkg::REG_PAT_LEN, len_word);

		phase_start = stream_items;
		while (stream_items - phase_start < 40) begin
			len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 24);
			s.delete();
			for (int i = 0; i < len; i++)
				s.push_back(($urandom_range(0, 7) == 0) ? ss_pkg::char_t'($urandom)
					: alpha[$urandom_range(0, 3)]);
			if (plen > 0 && plen <= len && $urandom_range(0, 1) != 0) begin
				case ($urandom_range(0, 3))
					0: at = 0;
					1: at = len - plen;
					default: at = $urandom_range(0, len - plen);
				endcase
				plant(s, pat, at, plen);
			end
			push_string(s, ($urandom_range(0, 5) == 0) ? CLOSE_BY_MARKER : CLOSE_ON_CHAR, 1'b1);
		end
		// leave a string running across the next pattern change now and then
		if ($urandom_range(0, 4) == 0) begin
			s.delete();
			repeat ($urandom_range(1, 6)) s.push_back(alpha[$urandom_range(0, 3)]);
			push_string(s, LEAVE_OPEN, 1'b0);
		end
		wait_idle();
	endtask

	task automatic long_strings();
		ss_pkg::char_t pat[ss_pkg::MAX_PATTERN];
		ss_pkg::char_t s[$];
		logic [ss_pkg::CFG_W-1:0] lo;
		lo = {$urandom, $urandom};
		for (int k = 0; k < ss_pkg::MAX_PATTERN; k++)
			pat[k] = (k < 8) ? lo[8*k +: 8] : 8'h00;
		write_reg(ss_pkg::REG_PAT_LOW, lo);
		write_reg(ss_pkg::REG_PAT_LEN, 64'd3);
		// exactly at the position limit: last match ends on the final character
		s.delete();
		repeat (ss_pkg::MAX_STRING_LEN) s.push_back(ss_pkg::char_t'($urandom));
		plant(s, pat, 0, 3);
		plant(s, pat, ss_pkg::MAX_STRING_LEN - 3, 3);
		push_string(s, CLOSE_ON_CHAR, 1'b0);
		// past the limit: late match is not recorded but still ends the string
		s.delete();
		repeat (ss_pkg::MAX_STRING_LEN + 3) s.push_back(ss_pkg::char_t'($urandom));
		plant(s, pat, ss_pkg::MAX_STRING_LEN - 4, 3);
		plant(s, pat, ss_pkg::MAX_STRING_LEN, 3);
		push_string(s, CLOSE_ON_CHAR, 1'b0);
		wait_idle();
	endtask

	initial begin : stimulus
		ss_pkg::char_t s[$];
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// empty pattern after reset
		push_item(ss_pkg::char_t'($urandom), 1'b0, 1'b1);
		push_item(8'hFF, 1'b1, 1'b1);
		push_item(8'h5A, 1'b0, 1'b0);
		push_item(8'h00, 1'b1, 1'b1);
		wait_idle();

		// two-byte pattern "ab"
		write_reg(ss_pkg::REG_PAT_LOW, 64'h6261);
		write_reg(ss_pkg::REG_PAT_HIGH, '0);
		write_reg(ss_pkg::REG_PAT_LEN, 64'd2);
		push_item(8'h00, 1'b0, 1'b1);
		s = '{8'h61};
		push_string(s, CLOSE_ON_CHAR, 1'b0);
		s = '{8'h61, 8'h62};
		push_string(s, CLOSE_ON_CHAR, 1'b0);
		s = '{8'h78, 8'h61, 8'h62, 8'h61, 8'h62};
		push_string(s, CLOSE_BY_MARKER, 1'b0);
		s = '{8'h78, 8'h61};
		push_string(s, LEAVE_OPEN, 1'b0);
		wait_idle();

		// full-width pattern with length saturating, continuing the open string
		write_reg(ss_pkg::REG_PAT_LOW, 64'hFF00_FF00_0000_FFFF);
		write_reg(ss_pkg::REG_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(ss_pkg::REG_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_UNUSED, {$urandom, $urandom});
		s = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		push_string(s, CLOSE_ON_CHAR, 1'b0);
		wait_idle();

		stream_items = 0;
		while (stream_items < RANDOM_ITEMS)
			random_phase();
		push_item(ss_pkg::char_t'($urandom), 1'b0, 1'b1);
		wait_idle();

		long_strings();

		if (fail_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/ss_pkg.sv
design/ss_cell.sv
design/ss_tracker.sv
design/substring_search.sv
sim/tb.sv
